### rtl/ami_pkg.sv
// Shared constants and types for the affine 2x3 matrix inverse.
package ami_pkg;

    localparam int COEF_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_LANES      = 6;

    // Lane order of the six quotients
    localparam int LANE_A = 0;
    localparam int LANE_B = 1;
    localparam int LANE_C = 2;
    localparam int LANE_D = 3;
    localparam int LANE_E = 4;
    localparam int LANE_F = 5;

    // Per-word flags carried down the divider pipeline
    typedef struct packed {
        logic                 sing;
        logic [NUM_LANES-1:0] ovf;
        logic [NUM_LANES-1:0] neg;
    } ami_flags_t;

endpackage

### rtl/ami_front.sv
// Front end: products, determinant, numerators, magnitudes and range check.
module ami_front #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic                                                 in_valid,
    output logic                                                 in_ready,
    input  logic signed [COEF_WIDTH-1:0]                         coef_a,
    input  logic signed [COEF_WIDTH-1:0]                         coef_b,
    input  logic signed [COEF_WIDTH-1:0]                         coef_c,
    input  logic signed [COEF_WIDTH-1:0]                         coef_d,
    input  logic signed [COEF_WIDTH-1:0]                         coef_e,
    input  logic signed [COEF_WIDTH-1:0]                         coef_f,
    output logic                                                 out_valid,
    input  logic                                                 out_ready,
    output logic [ami_pkg::NUM_LANES-1:0][2*COEF_WIDTH-1:0]      out_rem,
    output logic [ami_pkg::NUM_LANES-1:0][COEF_WIDTH:0]          out_lq,
    output logic [2*COEF_WIDTH-1:0]                              out_dm,
    output ami_pkg::ami_flags_t                                  out_flags
);
    import ami_pkg::*;

    localparam int W  = COEF_WIDTH;
    localparam int PW = 2 * W;
    localparam int DW = 2 * W + 1;
    localparam int NW = 2 * W + 1 + 2 * FRAC_BITS;
    localparam int RW = 2 * W;
    localparam int QB = W + 1;
    localparam int HW = NW + 1 - QB;
    localparam int CW = HW + RW;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld1, ld2, ld3, ld4;

    // Advance a stage when it is empty or its successor advances
    assign ld4       = !v4_reg || out_ready;
    assign ld3       = !v3_reg || ld4;
    assign ld2       = !v2_reg || ld3;
    assign ld1       = !v1_reg || ld2;
    assign in_ready  = ld1;
    assign out_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: six products
    logic signed [PW-1:0] ad_reg, bc_reg, cf_reg, de_reg, be_reg, af_reg;
    logic signed [W-1:0]  a1_reg, b1_reg, c1_reg, d1_reg;

    always_ff @(posedge aclk) begin
        if (ld1) begin
            ad_reg <= coef_a * coef_d;
            bc_reg <= coef_b * coef_c;
            cf_reg <= coef_c * coef_f;
            de_reg <= coef_d * coef_e;
            be_reg <= coef_b * coef_e;
            af_reg <= coef_a * coef_f;
            a1_reg <= coef_a;
            b1_reg <= coef_b;
            c1_reg <= coef_c;
            d1_reg <= coef_d;
        end
    end

    // Stage 2: determinant and signed numerators
    logic signed [DW-1:0] det_reg;
    logic [NUM_LANES-1:0][NW-1:0] num_reg;
    logic signed [DW-1:0] det_next, x4_next, x5_next;
    logic [NUM_LANES-1:0][NW-1:0] num_next;

    always_comb begin
        det_next = DW'(ad_reg) - DW'(bc_reg);
        x4_next  = DW'(cf_reg) - DW'(de_reg);
        x5_next  = DW'(be_reg) - DW'(af_reg);
        num_next[LANE_A] = NW'(d1_reg) <<< (2 * FRAC_BITS);
        num_next[LANE_B] = -(NW'(b1_reg) <<< (2 * FRAC_BITS));
        num_next[LANE_C] = -(NW'(c1_reg) <<< (2 * FRAC_BITS));
        num_next[LANE_D] = NW'(a1_reg) <<< (2 * FRAC_BITS);
        num_next[LANE_E] = NW'(x4_next) <<< FRAC_BITS;
        num_next[LANE_F] = NW'(x5_next) <<< FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (ld2) begin
            det_reg <= det_next;
            num_reg <= num_next;
        end
    end

    // Stage 3: magnitudes, doubled numerators, quotient signs
    logic [RW-1:0]                 dm3_reg;
    logic [NUM_LANES-1:0][NW:0]    tn_reg;
    logic [NUM_LANES-1:0]          neg3_reg;
    logic                          sing3_reg;
    logic [DW-1:0]                 det_abs;
    logic [NUM_LANES-1:0][NW-1:0]  num_abs;

    always_comb begin
        det_abs = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        for (int i = 0; i < NUM_LANES; i++) begin
            num_abs[i] = num_reg[i][NW-1] ? (~num_reg[i] + NW'(1)) : num_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld3) begin
            dm3_reg   <= det_abs[RW-1:0];
            sing3_reg <= (det_reg == '0);
            for (int i = 0; i < NUM_LANES; i++) begin
                tn_reg[i]   <= {num_abs[i], 1'b0};
                neg3_reg[i] <= num_reg[i][NW-1] ^ det_reg[DW-1];
            end
        end
    end

    // Stage 4: overflow check and initial remainder
    logic [NUM_LANES-1:0][RW-1:0] rem4_reg;
    logic [NUM_LANES-1:0][QB-1:0] lq4_reg;
    logic [RW-1:0]                dm4_reg;
    ami_flags_t                   flags4_reg;
    logic [NUM_LANES-1:0][CW-1:0] hi_ext;
    logic [NUM_LANES-1:0]         ovf_next;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            hi_ext[i]   = CW'(tn_reg[i][NW:QB]);
            ovf_next[i] = hi_ext[i] >= CW'(dm3_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld4) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                rem4_reg[i] <= ovf_next[i] ? '0 : hi_ext[i][RW-1:0];
                lq4_reg[i]  <= tn_reg[i][QB-1:0];
            end
            dm4_reg         <= dm3_reg;
            flags4_reg.sing <= sing3_reg;
            flags4_reg.ovf  <= ovf_next;
            flags4_reg.neg  <= neg3_reg;
        end
    end

    assign out_rem   = rem4_reg;
    assign out_lq    = lq4_reg;
    assign out_dm    = dm4_reg;
    assign out_flags = flags4_reg;

endmodule

### rtl/ami_div_stage.sv
// One restoring-division step for all six lanes, with its pipeline register.
module ami_div_stage #(
    parameter int COEF_WIDTH = 32
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic [ami_pkg::NUM_LANES-1:0][2*COEF_WIDTH-1:0] in_rem,
    input  logic [ami_pkg::NUM_LANES-1:0][COEF_WIDTH:0]     in_lq,
    input  logic [2*COEF_WIDTH-1:0]                         in_dm,
    input  ami_pkg::ami_flags_t                             in_flags,
    output logic                                            out_valid,
    input  logic                                            out_ready,
    output logic [ami_pkg::NUM_LANES-1:0][2*COEF_WIDTH-1:0] out_rem,
    output logic [ami_pkg::NUM_LANES-1:0][COEF_WIDTH:0]     out_lq,
    output logic [2*COEF_WIDTH-1:0]                         out_dm,
    output ami_pkg::ami_flags_t                             out_flags
);
    import ami_pkg::*;

    localparam int RW = 2 * COEF_WIDTH;
    localparam int QB = COEF_WIDTH + 1;

    logic                         v_reg;
    logic                         ld;
    logic [NUM_LANES-1:0][RW-1:0] rem_reg, rem_next;
    logic [NUM_LANES-1:0][QB-1:0] lq_reg, lq_next;
    logic [RW-1:0]                dm_reg;
    ami_flags_t                   flags_reg;
    logic [NUM_LANES-1:0][RW-1:0] rem_sh;
    logic [NUM_LANES-1:0][RW:0]   diff;

    assign ld        = !v_reg || out_ready;
    assign in_ready  = ld;
    assign out_valid = v_reg;

    // Shift in the next numerator bit, subtract when it fits
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            rem_sh[i]   = {in_rem[i][RW-2:0], in_lq[i][QB-1]};
            diff[i]     = {1'b0, rem_sh[i]} - {1'b0, in_dm};
            rem_next[i] = diff[i][RW] ? rem_sh[i] : diff[i][RW-1:0];
            lq_next[i]  = {in_lq[i][QB-2:0], !diff[i][RW]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (ld) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            rem_reg   <= rem_next;
            lq_reg    <= lq_next;
            dm_reg    <= in_dm;
            flags_reg <= in_flags;
        end
    end

    assign out_rem   = rem_reg;
    assign out_lq    = lq_reg;
    assign out_dm    = dm_reg;
    assign out_flags = flags_reg;

endmodule

### rtl/affine_matrix_inverse.sv
// Pipeline: four front stages, one division step per stage for COEF_WIDTH + 1 stages,
// then one round/saturate stage.
// Throughput: one matrix per cycle without output stalls; each stage moves on
// when empty or its successor moves, so bubbles close up under output stalls.
// Reset: aresetn (synchronous, active low) empties every stage; data is not cleared.
module affine_matrix_inverse #(
    parameter int COEF_WIDTH = ami_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = ami_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COEF_WIDTH-1:0] s_coef_a,
    input  logic signed [COEF_WIDTH-1:0] s_coef_b,
    input  logic signed [COEF_WIDTH-1:0] s_coef_c,
    input  logic signed [COEF_WIDTH-1:0] s_coef_d,
    input  logic signed [COEF_WIDTH-1:0] s_coef_e,
    input  logic signed [COEF_WIDTH-1:0] s_coef_f,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COEF_WIDTH-1:0] m_inv_a,
    output logic signed [COEF_WIDTH-1:0] m_inv_b,
    output logic signed [COEF_WIDTH-1:0] m_inv_c,
    output logic signed [COEF_WIDTH-1:0] m_inv_d,
    output logic signed [COEF_WIDTH-1:0] m_inv_e,
    output logic signed [COEF_WIDTH-1:0] m_inv_f,
    output logic                         m_invertible
);
    import ami_pkg::*;

    localparam int W  = COEF_WIDTH;
    localparam int RW = 2 * W;
    localparam int QB = W + 1;
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE_Q   =
        (FRAC_BITS >= W - 1) ? MAX_POS : (W'(1) << FRAC_BITS);

    logic [QB:0]                             dv, dr;
    logic [QB:0][NUM_LANES-1:0][RW-1:0]      drem;
    logic [QB:0][NUM_LANES-1:0][QB-1:0]      dlq;
    logic [QB:0][RW-1:0]                     ddm;
    ami_flags_t                              dflags [QB+1];

    ami_front #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .coef_a    (s_coef_a),
        .coef_b    (s_coef_b),
        .coef_c    (s_coef_c),
        .coef_d    (s_coef_d),
        .coef_e    (s_coef_e),
        .coef_f    (s_coef_f),
        .out_valid (dv[0]),
        .out_ready (dr[0]),
        .out_rem   (drem[0]),
        .out_lq    (dlq[0]),
        .out_dm    (ddm[0]),
        .out_flags (dflags[0])
    );

    // Chain of division steps
    for (genvar k = 0; k < QB; k++) begin : g_div
        ami_div_stage #(
            .COEF_WIDTH (COEF_WIDTH)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv[k]),
            .in_ready  (dr[k]),
            .in_rem    (drem[k]),
            .in_lq     (dlq[k]),
            .in_dm     (ddm[k]),
            .in_flags  (dflags[k]),
            .out_valid (dv[k+1]),
            .out_ready (dr[k+1]),
            .out_rem   (drem[k+1]),
            .out_lq    (dlq[k+1]),
            .out_dm    (ddm[k+1]),
            .out_flags (dflags[k+1])
        );
    end

    // Round half away from zero, saturate, pick identity when singular
    logic                          m_valid_reg;
    logic                          ld_out;
    logic [NUM_LANES-1:0][W-1:0]   inv_reg, inv_next;
    logic                          invertible_reg;
    logic [NUM_LANES-1:0][QB:0]    rsum;
    logic [NUM_LANES-1:0][QB-1:0]  rq;
    ami_flags_t                    fl;
    logic                          pos_sat, neg_sat;

    assign ld_out = !m_valid_reg || m_ready;
    assign dr[QB] = ld_out;
    assign fl     = dflags[QB];

    always_comb begin
        pos_sat = 1'b0;
        neg_sat = 1'b0;
        for (int i = 0; i < NUM_LANES; i++) begin
            rsum[i] = {1'b0, dlq[QB][i]} + (QB+1)'(1);
            rq[i]   = rsum[i][QB:1];
            if (fl.neg[i]) begin
                neg_sat = fl.ovf[i] || rq[i][W] || (rq[i][W-1] && (|rq[i][W-2:0]));
                inv_next[i] = neg_sat ? MIN_NEG : (~rq[i][W-1:0] + W'(1));
            end else begin
                pos_sat = fl.ovf[i] || (|rq[i][QB-1:W-1]);
                inv_next[i] = pos_sat ? MAX_POS : rq[i][W-1:0];
            end
        end
        if (fl.sing) begin
            inv_next         = '0;
            inv_next[LANE_A] = ONE_Q;
            inv_next[LANE_D] = ONE_Q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ld_out) begin
            m_valid_reg <= dv[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_out) begin
            inv_reg        <= inv_next;
            invertible_reg <= !fl.sing;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inv_a      = inv_reg[LANE_A];
    assign m_inv_b      = inv_reg[LANE_B];
    assign m_inv_c      = inv_reg[LANE_C];
    assign m_inv_d      = inv_reg[LANE_D];
    assign m_inv_e      = inv_reg[LANE_E];
    assign m_inv_f      = inv_reg[LANE_F];
    assign m_invertible = invertible_reg;

    // A singular word carries the identity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_invertible |-> m_inv_b == '0 && m_inv_c == '0 &&
            m_inv_e == '0 && m_inv_f == '0 && m_inv_a == ONE_Q && m_inv_d == ONE_Q)
        else $error("singular word without identity");

    // Input stalls only when the whole pipeline is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready && dv[QB])
        else $error("input stalled with an empty stage");

    // Flag at the last divider stage lands in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        dv[QB] && ld_out |=> m_valid && m_invertible == !$past(fl.sing))
        else $error("invertible flag lost");

endmodule
